// ===== rtl/lps_pkg.sv =====
// Package for the lookahead path steering block: shared constants, codes and the
// CORDIC arctangent table. No dependencies.
package lps_pkg;

  localparam int DEFAULT_PATH_DEPTH = 1024;

  // Field widths of the channels.
  localparam int COORD_W   = 32;
  localparam int SPEED_W   = 16;
  localparam int HEADING_W = 16;
  localparam int FLOOR_W   = 11;
  localparam int INDEX_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // Item codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Steering answers.
  localparam logic signed [1:0] STEER_LEFT  = -2'sd1;
  localparam logic signed [1:0] STEER_NONE  = 2'sd0;
  localparam logic signed [1:0] STEER_RIGHT = 2'sd1;

  // Register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOK_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOOK  = 2'd2;
  localparam logic [14:0] DEADBAND_RESET  = 15'd819;
  localparam logic [15:0] LOOK_TIME_RESET = 16'd205;
  localparam logic [23:0] MIN_LOOK_RESET  = 24'd256;

  // CORDIC and root iteration counts, angle constants in radians Q.16.
  localparam int CORDIC_STEPS = 16;
  localparam int ROOT_STEPS   = 16;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

  function automatic logic [15:0] atan_step(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      4'd15:   v = 16'd2;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/lps_if.sv =====
// Channel interfaces of the lookahead path steering block: items, results and
// register writes. Depends on lps_pkg.
interface lps_item_if import lps_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic                        new_path;
  logic signed [COORD_W-1:0]   coord_x;
  logic signed [COORD_W-1:0]   coord_y;
  logic signed [SPEED_W-1:0]   speed_x;
  logic signed [SPEED_W-1:0]   speed_y;
  logic signed [SPEED_W-1:0]   speed_z;
  logic signed [HEADING_W-1:0] heading;
  logic signed [FLOOR_W-1:0]   floor_index;

  modport source (output valid, opcode, new_path, coord_x, coord_y, speed_x, speed_y,
                  speed_z, heading, floor_index, input ready);
  modport sink   (input valid, opcode, new_path, coord_x, coord_y, speed_x, speed_y,
                  speed_z, heading, floor_index, output ready);
endinterface

interface lps_result_if import lps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [1:0]        steer_cmd;
  logic                     end_of_route;
  logic [INDEX_W-1:0]       nearest_index;
  logic [INDEX_W-1:0]       target_index;
  logic                     path_empty;

  modport source (output valid, steer_cmd, end_of_route, nearest_index, target_index,
                  path_empty, input ready);
  modport sink   (input valid, steer_cmd, end_of_route, nearest_index, target_index,
                  path_empty, output ready);
endinterface

interface lps_cfg_if import lps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lps_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module lps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic                            re,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lookahead_path_steering.sv =====
// Top level of the lookahead path steering block: path store, nearest and target
// scans, speed root, CORDIC bearing and deadband decision. Uses lps_pkg, lps_if, lps_ram.
//
//   channel  direction  beat content
//   item     in         load: path point (new_path restarts); query: vehicle state
//   result   out        steer_cmd, end_of_route, nearest_index, target_index, path_empty
//   cfg      in         register index and data (deadband, lookahead time, minimum)
//
// A load beat leaves the block in its idle state, so it stays ready for the next beat.
// A query scans from floor f to the last of the n stored points for the nearest one,
// then from the nearest point onward for the target: each scan streams one
// point per cycle through the RAM read port and a four-stage distance pipeline, the
// square root and CORDIC take 16 steps each, and seven further states join them.
// A query whose nearest point is the last point ends after the first scan, and a query
// on an empty path goes straight to the final state.
// Reset is synchronous; it empties the path and restores the register defaults.
// The RAM contents are not cleared, as only written points are ever read.
// A finished result waits in the output register while the next beat is accepted;
// a second result stalls in its final state until the first has been taken.
module lookahead_path_steering import lps_pkg::*; #(
  parameter int PATH_DEPTH = DEFAULT_PATH_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  lps_item_if.sink      item,
  lps_result_if.source  result,
  lps_cfg_if.sink       cfg
);

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CW = $clog2(PATH_DEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_NEAR  = 12'b000000000010,
    S_SQ    = 12'b000000000100,
    S_SUM   = 12'b000000001000,
    S_ROOT  = 12'b000000010000,
    S_LOOK  = 12'b000000100000,
    S_L2    = 12'b000001000000,
    S_TGT   = 12'b000010000000,
    S_AINIT = 12'b000100000000,
    S_ATAN  = 12'b001000000000,
    S_STEER = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state;

  // Configuration registers; writes are always taken.
  logic [14:0] angle_deadband;
  logic [15:0] lookahead_time;
  logic [23:0] min_lookahead;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_deadband <= DEADBAND_RESET;
      lookahead_time <= LOOK_TIME_RESET;
      min_lookahead  <= MIN_LOOK_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DEADBAND:  angle_deadband <= cfg.data[14:0];
        CFG_LOOK_TIME: lookahead_time <= cfg.data[15:0];
        CFG_MIN_LOOK:  min_lookahead  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Item handshake and path store. The RAM holds x in the upper and y in the
  // lower half of each word.
  logic          item_beat;
  logic          load_beat;
  logic          query_beat;
  logic          path_full;
  logic [CW-1:0] path_count;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] scan_addr;
  logic [63:0]   ram_rdata;

  assign item.ready = (state == S_IDLE);
  assign item_beat  = item.valid && item.ready;
  assign load_beat  = item_beat && (item.opcode == OP_LOAD);
  assign query_beat = item_beat && (item.opcode == OP_QUERY);
  assign path_full  = !(32'(path_count) < PATH_DEPTH);
  assign ram_we     = load_beat && (item.new_path || !path_full);
  assign ram_waddr  = item.new_path ? '0 : AW'(path_count);

  lps_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (PATH_DEPTH)
  ) u_path_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({item.coord_x, item.coord_y}),
    .re    (ram_re),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  // Query start: the floor is clamped to [0, last point].
  logic [INDEX_W-1:0] floor_u;
  logic [AW-1:0]      count_last;
  logic [AW-1:0]      floor_start;

  assign floor_u     = item.floor_index[FLOOR_W-1] ? '0 : item.floor_index[INDEX_W-1:0];
  assign count_last  = AW'(path_count - 1'b1);
  assign floor_start = (32'(floor_u) > 32'(path_count - 1'b1)) ? count_last : AW'(floor_u);

  // Captured query.
  logic signed [COORD_W-1:0]   q_x;
  logic signed [COORD_W-1:0]   q_y;
  logic signed [SPEED_W-1:0]   q_sx;
  logic signed [SPEED_W-1:0]   q_sy;
  logic signed [SPEED_W-1:0]   q_sz;
  logic signed [HEADING_W-1:0] q_heading;
  logic [AW-1:0]               last_idx;

  // Scan issue and the distance pipeline. Stage 1 meets the RAM read data.
  logic                 issuing;
  logic                 p1_v, p1_last;
  logic [AW-1:0]        p1_idx;
  logic                 p2_v, p2_last;
  logic [AW-1:0]        p2_idx;
  logic signed [32:0]   p2_dx, p2_dy;
  logic [32:0]          p2_ux, p2_uy;
  logic                 p3_v, p3_last;
  logic [AW-1:0]        p3_idx;
  logic signed [32:0]   p3_dx, p3_dy;
  logic [49:0]          p3_mxh, p3_myh;
  logic [48:0]          p3_mxl, p3_myl;
  logic                 p4_v, p4_last;
  logic [AW-1:0]        p4_idx;
  logic signed [32:0]   p4_dx, p4_dy;
  logic [65:0]          p4_d2;

  logic signed [32:0]   dx_c, dy_c;

  assign ram_re = issuing;
  assign dx_c   = $signed({ram_rdata[63], ram_rdata[63:32]}) - $signed({q_x[31], q_x});
  assign dy_c   = $signed({ram_rdata[31], ram_rdata[31:0]}) - $signed({q_y[31], q_y});

  always_ff @(posedge clk) begin
    p2_idx  <= p1_idx;
    p2_last <= p1_last;
    p2_dx   <= dx_c;
    p2_dy   <= dy_c;
    p2_ux   <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
    p2_uy   <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
    // Each square is split on bit 16 of its magnitude into two partial products.
    p3_idx  <= p2_idx;
    p3_last <= p2_last;
    p3_dx   <= p2_dx;
    p3_dy   <= p2_dy;
    p3_mxh  <= 50'(p2_ux) * 50'(p2_ux[32:16]);
    p3_mxl  <= 49'(p2_ux) * 49'(p2_ux[15:0]);
    p3_myh  <= 50'(p2_uy) * 50'(p2_uy[32:16]);
    p3_myl  <= 49'(p2_uy) * 49'(p2_uy[15:0]);
    p4_idx  <= p3_idx;
    p4_last <= p3_last;
    p4_dx   <= p3_dx;
    p4_dy   <= p3_dy;
    p4_d2   <= (66'(p3_mxh) << 16) + 66'(p3_mxl) + (66'(p3_myh) << 16) + 66'(p3_myl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
    end else begin
      p1_v <= issuing;
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;
    end
  end

  // Scan results, speed root, lookahead and CORDIC registers.
  logic [65:0]         best_d2;
  logic                have_best;
  logic [AW-1:0]       nearest;
  logic                found;
  logic [AW-1:0]       target;
  logic signed [32:0]  tx, ty;
  logic [31:0]         sqx, sqy, sqz;
  logic [33:0]         rv;
  logic [31:0]         rr;
  logic [30:0]         rbit;
  logic [3:0]          step;
  logic [23:0]         look;
  logic [47:0]         l2;
  logic signed [35:0]  cx, cy;
  logic signed [19:0]  cz;
  logic                czero;

  // Nearest update for the point leaving the pipeline.
  logic          near_take;
  logic [AW-1:0] near_new;
  assign near_take = p4_v && (!have_best || (p4_d2 < best_d2));
  assign near_new  = near_take ? p4_idx : nearest;

  // Square root step and lookahead product.
  logic [33:0] root_trial;
  logic [31:0] look_prod;
  assign root_trial = 34'(rr) + 34'(rbit);
  assign look_prod  = 32'(rr[15:0]) * 32'(lookahead_time);

  // CORDIC step.
  logic signed [35:0] cx_sh, cy_sh;
  logic signed [19:0] ctab;
  assign cx_sh = cx >>> step;
  assign cy_sh = cy >>> step;
  assign ctab  = $signed(20'(atan_step(step)));

  // Bearing error against the deadband, both in radians Q.16.
  logic signed [20:0] alpha;
  logic signed [20:0] db;
  assign alpha = 21'(cz) - 21'($signed({q_heading, 3'b000}));
  assign db    = $signed({3'b000, angle_deadband, 3'b000});

  // Result staging and output register.
  logic              pend_empty;
  logic              pend_end;
  logic              res_valid;

  assign result.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      path_count <= '0;
      issuing    <= 1'b0;
      res_valid  <= 1'b0;
      have_best  <= 1'b0;
      found      <= 1'b0;
    end else begin
      // The final state reloads the output register itself when it is taken.
      if (result.valid && result.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end

      if (issuing) begin
        p1_idx  <= scan_addr;
        p1_last <= (scan_addr == last_idx);
        if (scan_addr == last_idx) begin
          issuing <= 1'b0;
        end else begin
          scan_addr <= scan_addr + 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (load_beat) begin
            if (item.new_path) begin
              path_count <= CW'(1);
            end else if (!path_full) begin
              path_count <= path_count + 1'b1;
            end
          end
          if (query_beat) begin
            q_x       <= item.coord_x;
            q_y       <= item.coord_y;
            q_sx      <= item.speed_x;
            q_sy      <= item.speed_y;
            q_sz      <= item.speed_z;
            q_heading <= item.heading;
            last_idx  <= count_last;
            if (path_count == '0) begin
              pend_empty <= 1'b1;
              pend_end   <= 1'b0;
              nearest    <= '0;
              target     <= '0;
              state      <= S_DONE;
            end else begin
              pend_empty <= 1'b0;
              have_best  <= 1'b0;
              issuing    <= 1'b1;
              scan_addr  <= floor_start;
              state      <= S_NEAR;
            end
          end
        end

        S_NEAR: begin
          if (near_take) begin
            best_d2   <= p4_d2;
            nearest   <= p4_idx;
            have_best <= 1'b1;
          end
          if (p4_v && p4_last) begin
            if (near_new == last_idx) begin
              // End of route: no lookahead and no turn.
              pend_end   <= 1'b1;
              target     <= near_new;
              state      <= S_DONE;
            end else begin
              pend_end <= 1'b0;
              state    <= S_SQ;
            end
          end
        end

        S_SQ: begin
          sqx   <= 32'(q_sx) * 32'(q_sx);
          sqy   <= 32'(q_sy) * 32'(q_sy);
          sqz   <= 32'(q_sz) * 32'(q_sz);
          state <= S_SUM;
        end

        S_SUM: begin
          rv    <= 34'(sqx) + 34'(sqy) + 34'(sqz);
          rr    <= '0;
          rbit  <= 31'(1) << 30;
          step  <= '0;
          state <= S_ROOT;
        end

        S_ROOT: begin
          if (rv >= root_trial) begin
            rv <= rv - root_trial;
            rr <= (rr >> 1) + 32'(rbit);
          end else begin
            rr <= rr >> 1;
          end
          rbit <= rbit >> 2;
          step <= step + 1'b1;
          if (step == 4'(ROOT_STEPS - 1)) begin
            state <= S_LOOK;
          end
        end

        S_LOOK: begin
          look  <= (look_prod[31:8] < min_lookahead) ? min_lookahead : look_prod[31:8];
          state <= S_L2;
        end

        S_L2: begin
          l2        <= 48'(look) * 48'(look);
          found     <= 1'b0;
          issuing   <= 1'b1;
          scan_addr <= nearest;
          state     <= S_TGT;
        end

        S_TGT: begin
          // First point at least the lookahead away, else the last point.
          if (p4_v && !found && ((p4_d2 >= 66'(l2)) || p4_last)) begin
            found  <= 1'b1;
            target <= p4_idx;
            tx     <= p4_dx;
            ty     <= p4_dy;
          end
          if (p4_v && p4_last) begin
            state <= S_AINIT;
          end
        end

        S_AINIT: begin
          // Pre-rotate the left half-plane by a quarter turn.
          czero <= (tx == '0) && (ty == '0);
          step  <= '0;
          if (tx[32] && !ty[32]) begin
            cx <= 36'(ty);
            cy <= -36'(tx);
            cz <= HALF_PI_Q16;
          end else if (tx[32]) begin
            cx <= -36'(ty);
            cy <= 36'(tx);
            cz <= -HALF_PI_Q16;
          end else begin
            cx <= 36'(tx);
            cy <= 36'(ty);
            cz <= '0;
          end
          state <= S_ATAN;
        end

        S_ATAN: begin
          if (cy > 0) begin
            cx <= cx + cy_sh;
            cy <= cy - cx_sh;
            cz <= cz + ctab;
          end else begin
            cx <= cx - cy_sh;
            cy <= cy + cx_sh;
            cz <= cz - ctab;
          end
          step <= step + 1'b1;
          if (step == 4'(CORDIC_STEPS - 1)) begin
            state <= S_STEER;
          end
        end

        S_STEER: begin
          if (czero) begin
            cz <= '0;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid            <= 1'b1;
            result.end_of_route  <= pend_end;
            result.path_empty    <= pend_empty;
            result.nearest_index <= INDEX_W'(nearest);
            result.target_index  <= INDEX_W'(target);
            if (pend_empty || pend_end) begin
              result.steer_cmd <= STEER_NONE;
            end else if (alpha > db) begin
              result.steer_cmd <= STEER_LEFT;
            end else if (alpha < -db) begin
              result.steer_cmd <= STEER_RIGHT;
            end else begin
              result.steer_cmd <= STEER_NONE;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The path never holds more points than the store has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(path_count) <= PATH_DEPTH)
    else $error("path count beyond store depth");

  // A new result only appears out of the final state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the final state");

  // The lookahead target never lies before the nearest point.
  a_target_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_AINIT) |-> (found && (target >= nearest)))
    else $error("target before nearest point");

  // Scans are only issued while a query is being worked on.
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    issuing |-> (state == S_NEAR || state == S_TGT))
    else $error("scan issued outside a query");

endmodule
